/* rtl/rfb_pkg.sv */
// Shared types and constants for the row feather blender.
// Used by rfb_recip and row_feather_blend; depends on nothing else.

package rfb_pkg;

	// Blend weights are unsigned Q1.FRAC_BITS.
	localparam int FRAC_BITS = 16;
	localparam int W_BITS    = FRAC_BITS + 1;
	localparam logic [W_BITS-1:0] W_ONE  = W_BITS'(1) << FRAC_BITS;
	localparam logic [W_BITS-1:0] W_HALF = W_BITS'(1) << (FRAC_BITS - 1);

	// Row geometry.
	localparam int MAX_WIDTH = 4096;
	localparam int WIDTH_W   = 13;
	localparam int COL_W     = 12;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

	// BT.601 luma weights over 2^14; a rounded luma is nonzero once the
	// weighted sum reaches half of the scale.
	localparam int LUMA_W = 22;
	localparam logic [LUMA_W-1:0] LUMA_KB     = LUMA_W'(1868);
	localparam logic [LUMA_W-1:0] LUMA_KG     = LUMA_W'(9617);
	localparam logic [LUMA_W-1:0] LUMA_KR     = LUMA_W'(4899);
	localparam logic [LUMA_W-1:0] LUMA_THRESH = LUMA_W'(8192);

	// Width of the signed mixing accumulator.
	localparam int MIX_W = FRAC_BITS + 11;

	typedef struct packed {
		logic [7:0] base_blue;
		logic [7:0] base_green;
		logic [7:0] base_red;
		logic [7:0] overlay_blue;
		logic [7:0] overlay_green;
		logic [7:0] overlay_red;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       in_overlap;
		logic       row_end;
	} pix_out_t;

endpackage

/* rtl/rfb_recip.sv */
// Bit-serial restoring divider that forms W_ONE / span for the blend step.
// Depends on rfb_pkg for the weight and width constants.

module rfb_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rfb_pkg::WIDTH_W-1:0] span,
	output logic                        done,
	output logic [rfb_pkg::W_BITS-1:0]  quotient
);
	import rfb_pkg::*;

	localparam int CNT_W = $clog2(W_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WIDTH_W-1:0]  rem_q;
	logic [WIDTH_W-1:0]  span_q;
	logic [W_BITS-1:0]   quo_q;

	logic [WIDTH_W:0]    rem_sh;
	logic [WIDTH_W:0]    rem_sub;
	logic                fits;

	// One quotient bit per cycle: the dividend shifts out of the top of
	// quo_q while quotient bits shift in at the bottom.
	always_comb begin
		rem_sh  = {rem_q, quo_q[W_BITS-1]};
		rem_sub = rem_sh - {1'b0, span_q};
		fits    = (rem_sh >= {1'b0, span_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			span_q <= span;
			quo_q  <= W_ONE;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[WIDTH_W-1:0] : rem_sh[WIDTH_W-1:0];
			quo_q <= {quo_q[W_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/row_feather_blend.sv */
// Row feather blender top level: column tracking, luma test, weight update
// and a shared per-channel mixing multiplier. Depends on rfb_pkg, rfb_recip.
// A pixel passes the luma test, then for overlap the reciprocal division (first
// overlap pixel of a row only) and the channel mixing, then the output register.
// Input is taken only while idle; the multiplier mixes one color channel a cycle.
// Reset sets the row width to 640 and clears control state, not the pixel payload.

module row_feather_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rfb_pkg::WIDTH_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rfb_pkg::pix_in_t            in_pix,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rfb_pkg::pix_out_t           out_pix
);
	import rfb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LUMA,
		S_DIV,
		S_MIX,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [WIDTH_W-1:0]  row_width_q;
	logic [COL_W-1:0]    col_q;
	logic                seen_q;
	logic [W_BITS-1:0]   weight_q;
	logic [W_BITS-1:0]   step_q;
	logic                overlap_q;
	logic                last_q;
	logic [1:0]          chan_q;
	logic [7:0]          res_b_q;
	logic [7:0]          res_g_q;
	logic [7:0]          res_r_q;
	pix_in_t             pix_q;
	pix_out_t            out_q;
	logic                out_valid_q;

	logic [WIDTH_W-1:0]  eff_width;
	logic [WIDTH_W-1:0]  col_ext;
	logic                last_now;
	logic [WIDTH_W-1:0]  span;
	logic [LUMA_W-1:0]   luma_sum;
	logic                overlap_now;
	logic [W_BITS:0]     weight_sum;
	logic [W_BITS-1:0]   weight_next;
	logic                div_start;
	logic                div_done;
	logic [W_BITS-1:0]   div_quo;
	logic [7:0]          mix_ov;
	logic [7:0]          mix_base;
	logic signed [8:0]   mix_diff;
	logic signed [MIX_W-1:0] mix_prod;
	logic signed [MIX_W-1:0] mix_acc;
	logic [7:0]          mix_res;
	logic                out_free;
	logic                in_beat;
	logic                out_beat;

	// Clamp the configured width to the supported range.
	always_comb begin
		if (row_width_q == '0) begin
			eff_width = WIDTH_W'(1);
		end else if (row_width_q > WIDTH_MAX) begin
			eff_width = WIDTH_MAX;
		end else begin
			eff_width = row_width_q;
		end
		col_ext  = {1'b0, col_q};
		last_now = (col_ext >= eff_width - WIDTH_W'(1));
		span     = (col_ext < eff_width) ? (eff_width - col_ext) : WIDTH_W'(1);
	end

	// Overlap test on the latched overlay pixel.
	always_comb begin
		luma_sum = LUMA_W'(pix_q.overlay_blue) * LUMA_KB
			+ LUMA_W'(pix_q.overlay_green) * LUMA_KG
			+ LUMA_W'(pix_q.overlay_red) * LUMA_KR;
		overlap_now = (luma_sum >= LUMA_THRESH);
	end

	// Weight advance with saturation at one.
	always_comb begin
		weight_sum  = {1'b0, weight_q} + {1'b0, step_q};
		weight_next = (weight_sum > {1'b0, W_ONE}) ? W_ONE : weight_sum[W_BITS-1:0];
	end

	// Shared mixer: base*ONE + (overlay - base)*w + half, one channel a cycle.
	always_comb begin
		unique case (chan_q)
			2'd0: begin
				mix_ov   = pix_q.overlay_blue;
				mix_base = pix_q.base_blue;
			end
			2'd1: begin
				mix_ov   = pix_q.overlay_green;
				mix_base = pix_q.base_green;
			end
			default: begin
				mix_ov   = pix_q.overlay_red;
				mix_base = pix_q.base_red;
			end
		endcase
		mix_diff = $signed({1'b0, mix_ov}) - $signed({1'b0, mix_base});
		mix_prod = MIX_W'(mix_diff * $signed({1'b0, weight_q}));
		mix_acc  = $signed(MIX_W'({mix_base, FRAC_BITS'(0)})) + mix_prod
			+ $signed(MIX_W'(W_HALF));
		if ((mix_acc >>> (FRAC_BITS + 8)) != '0) begin
			mix_res = 8'hFF;
		end else begin
			mix_res = mix_acc[FRAC_BITS+7:FRAC_BITS];
		end
	end

	assign div_start = (state_q == S_LUMA) && overlap_now && !seen_q;

	rfb_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.span     (span),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			row_width_q <= cfg_wr_data;
		end
	end

	// Sequencer with row state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			seen_q      <= 1'b0;
			weight_q    <= '0;
			step_q      <= '0;
			overlap_q   <= 1'b0;
			last_q      <= 1'b0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_LUMA;
					end
				end
				S_LUMA: begin
					overlap_q <= overlap_now;
					last_q    <= last_now;
					chan_q    <= '0;
					col_q     <= last_now ? '0 : col_q + 1'b1;
					if (overlap_now && !seen_q) begin
						seen_q   <= 1'b1;
						weight_q <= '0;
						state_q  <= S_DIV;
					end else if (overlap_now) begin
						weight_q <= weight_next;
						state_q  <= S_MIX;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						step_q  <= div_quo;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (chan_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						chan_q <= chan_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (last_q) begin
							seen_q   <= 1'b0;
							weight_q <= '0;
							step_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// The output beat is loaded by the sequencer and dropped once taken.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pixel and result payload registers.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			pix_q <= in_pix;
		end
		if (state_q == S_LUMA) begin
			res_b_q <= pix_q.base_blue;
			res_g_q <= pix_q.base_green;
			res_r_q <= pix_q.base_red;
		end else if (state_q == S_MIX) begin
			unique case (chan_q)
				2'd0:    res_b_q <= mix_res;
				2'd1:    res_g_q <= mix_res;
				default: res_r_q <= mix_res;
			endcase
		end
		if (state_q == S_OUT && out_free) begin
			out_q.out_blue   <= res_b_q;
			out_q.out_green  <= res_g_q;
			out_q.out_red    <= res_r_q;
			out_q.in_overlap <= overlap_q;
			out_q.row_end    <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_q;

endmodule

/* tb/feather_blend_checker.sv */
// Checker for the row feather blender: watches the configuration port and both pixel channels.
// It predicts each blended pixel and compares it with the block's output beats.
// Depends on rfb_pkg.

module feather_blend_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rfb_pkg::WIDTH_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  rfb_pkg::pix_in_t            in_pix,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  rfb_pkg::pix_out_t           out_pix,
	output int                          fails,
	output int                          pending
);
	import rfb_pkg::*;

	localparam int unsigned ONE  = 1 << FRAC_BITS;
	localparam int unsigned HALF = 1 << (FRAC_BITS - 1);

	// Shadow of the row width register and of the blender's row state.
	logic [WIDTH_W-1:0] width_reg;
	int unsigned        col_pos;
	bit                 feather_on;
	int unsigned        weight_q;
	int unsigned        step_q;

	// Blended pixels that are still owed by the block, oldest first.
	pix_out_t           blended_q[$];

	// The rounded BT.601 luma is nonzero once the weighted sum reaches half a step.
	function automatic bit luma_nonzero(input pix_in_t p);
		int unsigned acc;
		acc = 1868 * p.overlay_blue + 9617 * p.overlay_green + 4899 * p.overlay_red;
		return ((acc + 8192) >> 14) != 0;
	endfunction

	// One channel: overlay weighted by w, base by one minus w, rounded and clamped.
	function automatic logic [7:0] mix_chan(input logic [7:0] ov, input logic [7:0] bs,
		input int unsigned w);
		int unsigned o;
		int unsigned b;
		int unsigned acc;
		o = ov;
		b = bs;
		acc = (o * w + b * (ONE - w) + HALF) >> FRAC_BITS;
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	// Works out the blended pixel for one input beat and advances the row state.
	task automatic blend_predict(input pix_in_t p, output pix_out_t r);
		int unsigned w_eff;
		int unsigned span;
		bit          ovl;
		bit          last;
		if (width_reg == 0)
			w_eff = 1;
		else if (width_reg > MAX_WIDTH)
			w_eff = MAX_WIDTH;
		else
			w_eff = width_reg;
		ovl = luma_nonzero(p);
		r = '0;
		if (ovl) begin
			if (!feather_on) begin
				// First overlap pixel of the row: the ramp starts at zero here.
				span = (col_pos < w_eff) ? (w_eff - col_pos) : 1;
				feather_on = 1'b1;
				weight_q = 0;
				step_q = ONE / span;
			end else begin
				weight_q += step_q;
				if (weight_q > ONE)
					weight_q = ONE;
			end
			r.out_blue  = mix_chan(p.overlay_blue, p.base_blue, weight_q);
			r.out_green = mix_chan(p.overlay_green, p.base_green, weight_q);
			r.out_red   = mix_chan(p.overlay_red, p.base_red, weight_q);
		end else begin
			r.out_blue  = p.base_blue;
			r.out_green = p.base_green;
			r.out_red   = p.base_red;
		end
		last = col_pos >= w_eff - 1;
		r.in_overlap = ovl;
		r.row_end = last;
		// The row ends on the last column, or at once if the width was lowered past it.
		if (last) begin
			col_pos = 0;
			feather_on = 1'b0;
			weight_q = 0;
			step_q = 0;
		end else begin
			col_pos++;
		end
	endtask

	task automatic check_channel(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Predict on every accepted input beat, compare on every accepted output beat.
	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			col_pos = 0;
			feather_on = 1'b0;
			weight_q = 0;
			step_q = 0;
			blended_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				width_reg = cfg_wr_data;
			if (in_valid && !in_stall) begin
				blend_predict(in_pix, want);
				blended_q = {blended_q, want};
			end
			if (out_valid && !out_stall) begin
				if (blended_q.size() == 0) begin
					$error("output beat with no pixel outstanding");
					fails++;
				end else begin
					want = blended_q.pop_front();
					check_channel("out_blue", want.out_blue, out_pix.out_blue);
					check_channel("out_green", want.out_green, out_pix.out_green);
					check_channel("out_red", want.out_red, out_pix.out_red);
					check_channel("in_overlap", want.in_overlap, out_pix.in_overlap);
					check_channel("row_end", want.row_end, out_pix.row_end);
				end
			end
			pending = blended_q.size();
		end
	end

endmodule

/* tb/row_feather_blend_tb.sv */
// Testbench top for the row feather blender: clock, reset, pixel stimulus and verdict.
// Prediction and comparison live in feather_blend_checker.
// Depends on rfb_pkg, row_feather_blend and feather_blend_checker.

module row_feather_blend_tb;
	import rfb_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [WIDTH_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	pix_in_t            in_pix;
	logic               out_valid;
	logic               out_stall;
	pix_out_t           out_pix;
	int                 fails;
	int                 pending;

	// Stimulus controls: calm turns idling off, hold_req asks the receiver for a long stall.
	bit                 calm;
	bit                 hold_req;
	bit                 hold_done;

	// Rough row position used only to give the random rows a feathering shape.
	int unsigned        cur_width;
	int unsigned        row_col;
	int unsigned        ovl_start;

	int unsigned        phase_width[12] = '{5, 1, 17, 8191, 3, 640, 32, 2, 4096, 9, 64, 12};

	always #5 clk = ~clk;

	row_feather_blend dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_pix      (in_pix),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pix     (out_pix)
	);

	feather_blend_checker blend_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_pix      (in_pix),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pix     (out_pix),
		.fails       (fails),
		.pending     (pending)
	);

	// Watchdog for a hung run.
	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stalls, or one long hold that lets the block fill up.
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 28);
			end
		end
	end

	function automatic pix_in_t pixel(input logic [7:0] bb, input logic [7:0] bg,
		input logic [7:0] br, input logic [7:0] ob, input logic [7:0] og, input logic [7:0] orr);
		pix_in_t p;
		p.base_blue = bb;
		p.base_green = bg;
		p.base_red = br;
		p.overlay_blue = ob;
		p.overlay_green = og;
		p.overlay_red = orr;
		return p;
	endfunction

	// Mostly rows that are empty up to a random column and covered after it; the rest is
	// near the luma threshold or fully random.
	function automatic pix_in_t next_pixel();
		pix_in_t     p;
		int unsigned roll;
		p = pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		roll = $urandom_range(99);
		if (roll < 70) begin
			if (row_col >= ovl_start) begin
				p.overlay_green = 8'($urandom_range(1, 255));
			end else begin
				p.overlay_blue = '0;
				p.overlay_green = '0;
				p.overlay_red = '0;
			end
		end else if (roll < 85) begin
			p.overlay_blue = 8'($urandom_range(0, 5));
			p.overlay_green = '0;
			p.overlay_red = 8'($urandom_range(0, 2));
		end
		return p;
	endfunction

	// Offers one beat, holding it steady until the block takes it.
	task automatic offer_pixel(input pix_in_t p);
		if (!calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_pix <= p;
		do
			@(posedge clk);
		while (in_stall);
		row_col++;
		if (row_col >= cur_width) begin
			row_col = 0;
			ovl_start = $urandom_range(0, cur_width);
		end
	endtask

	// Waits until every blended pixel has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width(input int unsigned w);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= WIDTH_W'(w);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (w == 0)
			cur_width = 1;
		else if (w > MAX_WIDTH)
			cur_width = MAX_WIDTH;
		else
			cur_width = w;
		if (row_col >= cur_width)
			row_col = 0;
		ovl_start = $urandom_range(0, cur_width);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_pix = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_width = 640;
		row_col = 0;
		ovl_start = $urandom_range(0, 640);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Luma threshold cases and channel extremes at the reset width.
		offer_pixel(pixel(0, 0, 0, 0, 0, 0));
		offer_pixel(pixel(255, 255, 255, 4, 0, 0));
		offer_pixel(pixel(255, 0, 255, 0, 0, 1));
		offer_pixel(pixel(128, 64, 32, 1, 0, 1));
		offer_pixel(pixel(255, 255, 255, 5, 0, 0));
		offer_pixel(pixel(0, 0, 0, 0, 1, 0));
		offer_pixel(pixel(17, 200, 90, 0, 0, 2));
		offer_pixel(pixel(0, 0, 0, 255, 255, 255));
		offer_pixel(pixel(255, 255, 255, 255, 255, 255));
		offer_pixel(pixel(1, 2, 3, 0, 0, 0));

		// Width lowered below the current column: the next pixel closes the row.
		set_width(2);
		offer_pixel(pixel(9, 9, 9, 200, 100, 50));
		offer_pixel(pixel(40, 80, 120, 250, 10, 60));

		// Width raised after the ramp was sized, so the weight runs into its ceiling.
		set_width(8);
		repeat (7)
			offer_pixel(pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom_range(1, 255)), 8'($urandom)));

		// First overlap found past the end of a narrowed row; zero width acts as one.
		set_width(4096);
		repeat (3)
			offer_pixel(pixel(8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0));
		set_width(0);
		offer_pixel(pixel(0, 0, 0, 255, 0, 0));
		offer_pixel(pixel(255, 255, 255, 0, 255, 0));
		offer_pixel(pixel(100, 150, 200, 0, 0, 255));

		// Random rows over a range of widths, with one long output hold and one calm phase.
		for (int i = 0; i < 12; i++) begin
			set_width(phase_width[i]);
			if (i == 2)
				hold_req = 1'b1;
			calm = (i == 5);
			repeat (130)
				offer_pixel(next_pixel());
		end
		calm = 1'b0;

		drain();
		repeat (30) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
